// ===== src/ntd_pkg.sv =====
// ----------------------------------------------------------------------------
// ntd_pkg: shared types and constants for the note doubler
// Field widths, counter memory geometry and the shared unit's interface.
// ----------------------------------------------------------------------------
package ntd_pkg;

   // field widths
   localparam int ChanW  = 4;
   localparam int KeyW   = 7;
   localparam int VelW   = 7;
   localparam int ShiftW = 6;
   localparam int CountW = 8;

   // counter memory geometry
   localparam int Channels = 16;
   localparam int Keys     = 128;
   localparam int Depth    = Channels * Keys;
   localparam int AddrW    = $clog2(Depth);

   // channel bound, one bit wider than the channel field
   localparam logic [ChanW:0] ChanLimit = (ChanW + 1)'(Channels);

   // reset value of the key shift register
   localparam logic signed [ShiftW-1:0] ShiftReset = ShiftW'(7);

   // saturation limits of a counter
   localparam logic signed [CountW-1:0] CountMax = CountW'(127);
   localparam logic signed [CountW-1:0] CountMin = CountW'(-128);

   // top key number
   localparam logic [KeyW-1:0] KeyMax = KeyW'(Keys - 1);

   // operation of the shared unit
   typedef enum logic {
      ALU_CLAMP = 1'b0,
      ALU_BUMP  = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type                 op;
      logic                       note_on;
      logic [KeyW-1:0]            key;
      logic signed [ShiftW-1:0]   shift;
      logic signed [CountW-1:0]   count;
   } alu_req_type;

   typedef struct packed {
      logic [KeyW-1:0]            key;
      logic signed [CountW-1:0]   count;
      logic                       emit;
   } alu_rsp_type;

endpackage

// ===== src/ntd_ifs.sv =====
// ----------------------------------------------------------------------------
// ntd_ifs: channel interfaces of the note doubler
// Note event input, note event output and key shift register write.
// ----------------------------------------------------------------------------
interface ntd_req_if;
   logic                          valid;
   logic                          ready;
   logic                          note_on;
   logic [ntd_pkg::ChanW-1:0]     channel;
   logic [ntd_pkg::KeyW-1:0]      key;
   logic [ntd_pkg::VelW-1:0]      velocity;

   modport source (output valid, note_on, channel, key, velocity, input ready);
   modport sink   (input valid, note_on, channel, key, velocity, output ready);
endinterface

interface ntd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          out_note_on;
   logic [ntd_pkg::ChanW-1:0]     out_channel;
   logic [ntd_pkg::KeyW-1:0]      out_key;
   logic [ntd_pkg::VelW-1:0]      out_velocity;
   logic                          is_shifted;
   logic                          last;

   modport source (output valid, out_note_on, out_channel, out_key, out_velocity,
                   is_shifted, last, input ready);
   modport sink   (input valid, out_note_on, out_channel, out_key, out_velocity,
                   is_shifted, last, output ready);
endinterface

interface ntd_csr_if;
   logic                               valid;
   logic                               ready;
   logic signed [ntd_pkg::ShiftW-1:0]  data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== src/ntd_alu.sv =====
// ----------------------------------------------------------------------------
// ntd_alu: shared adder of the note doubler
// Forms the clamped companion key, or steps a saturating reference count.
// ----------------------------------------------------------------------------
module ntd_alu (
   input  ntd_pkg::alu_req_type  alu_req,
   output ntd_pkg::alu_rsp_type  alu_rsp
);

   logic signed [8:0]                 operand_a;
   logic signed [8:0]                 operand_b;
   logic signed [8:0]                 sum;
   logic                              saturated;
   logic signed [ntd_pkg::CountW-1:0] next_count;

   // operand select for the one adder
   always_comb begin
      if (alu_req.op == ntd_pkg::ALU_CLAMP) begin
         operand_a = {2'b00, alu_req.key};
         operand_b = {{3{alu_req.shift[ntd_pkg::ShiftW-1]}}, alu_req.shift};
      end else begin
         operand_a = {alu_req.count[ntd_pkg::CountW-1], alu_req.count};
         operand_b = alu_req.note_on ? 9'sd1 : -9'sd1;
      end
   end

   assign sum = operand_a + operand_b;

   // count holds at its limit
   assign saturated = alu_req.note_on ? (alu_req.count == ntd_pkg::CountMax)
                                      : (alu_req.count == ntd_pkg::CountMin);
   assign next_count = saturated ? alu_req.count : sum[ntd_pkg::CountW-1:0];

   // clamp key, report count transitions
   always_comb begin
      if (sum < 9'sd0) begin
         alu_rsp.key = '0;
      end else if (sum > 9'sd127) begin
         alu_rsp.key = ntd_pkg::KeyMax;
      end else begin
         alu_rsp.key = sum[ntd_pkg::KeyW-1:0];
      end
      alu_rsp.count = next_count;
      alu_rsp.emit  = !saturated &&
                      (alu_req.note_on ? (next_count == 8'sd1) : (next_count == 8'sd0));
   end

endmodule

// ===== src/note_transpose_doubler_refcount.sv =====
// ----------------------------------------------------------------------------
// note_transpose_doubler_refcount: note doubler with transpose and ref counts
// Keeps a saturating count per channel and key; emits note events on the
// original key and a shifted companion key when their counts cross 0/1.
// ----------------------------------------------------------------------------
// The first result reaches the output register after both counter updates.
// A new event is taken only once the last one's results are handed on, which
// an output stall delays; the one-read-port counter memory and shared adder
// serialise the steps. Reset: synchronous; a clearing pass then zeroes the 2048
// counters, one per cycle, and no event is taken until it ends. Key shift resets to 7.
module note_transpose_doubler_refcount (
   input  logic          clock,
   input  logic          reset,
   ntd_req_if.sink       req_bus,
   ntd_rsp_if.source     rsp_bus,
   ntd_csr_if.sink       csr_bus
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SHIFT = 7'b0000100,
      ST_UP0   = 7'b0001000,
      ST_READ1 = 7'b0010000,
      ST_UP1   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [ntd_pkg::AddrW-1:0]          clr_addr_ff, clr_addr_in;
   logic signed [ntd_pkg::ShiftW-1:0]  key_shift_ff, key_shift_in;

   // captured event
   logic                               on_ff;
   logic [ntd_pkg::ChanW-1:0]          ch_ff;
   logic [ntd_pkg::KeyW-1:0]           key_ff;
   logic [ntd_pkg::VelW-1:0]           vel_ff;
   logic [ntd_pkg::KeyW-1:0]           nk_ff, nk_in;
   logic                               emit0_ff, emit0_in;
   logic                               emit1_ff, emit1_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_on_ff;
   logic [ntd_pkg::ChanW-1:0]          rsp_ch_ff;
   logic [ntd_pkg::KeyW-1:0]           rsp_key_ff;
   logic [ntd_pkg::VelW-1:0]           rsp_vel_ff;
   logic                               rsp_shifted_ff;
   logic                               rsp_last_ff;
   logic                               out_load;
   logic [ntd_pkg::KeyW-1:0]           out_key;
   logic                               out_shifted;
   logic                               out_last;

   // counter memory
   logic signed [ntd_pkg::CountW-1:0]  mem [ntd_pkg::Depth];
   logic signed [ntd_pkg::CountW-1:0]  rd_data_ff;
   logic [ntd_pkg::AddrW-1:0]          rd_addr;
   logic [ntd_pkg::AddrW-1:0]          wr_addr;
   logic signed [ntd_pkg::CountW-1:0]  wr_data;
   logic                               wr_en;
   logic [ntd_pkg::ChanW+ntd_pkg::KeyW-1:0] key_full;
   logic [ntd_pkg::ChanW+ntd_pkg::KeyW-1:0] nk_full;
   logic [ntd_pkg::AddrW-1:0]          key_addr;
   logic [ntd_pkg::AddrW-1:0]          nk_addr;

   logic                               req_take;
   logic                               ch_ok;
   logic                               out_free;

   ntd_pkg::alu_req_type               alu_req;
   ntd_pkg::alu_rsp_type               alu_rsp;

   ntd_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // addresses of the two counters
   assign key_full = {ch_ff, key_ff};
   assign nk_full  = {ch_ff, nk_ff};
   assign key_addr = key_full[ntd_pkg::AddrW-1:0];
   assign nk_addr  = nk_full[ntd_pkg::AddrW-1:0];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign ch_ok         = ({1'b0, req_bus.channel} < ntd_pkg::ChanLimit);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   // register write port
   assign csr_bus.ready = 1'b1;
   assign key_shift_in  = (csr_bus.valid && csr_bus.ready) ? csr_bus.data : key_shift_ff;

   // shared unit operands
   always_comb begin
      alu_req.op      = (state_ff == ST_SHIFT) ? ntd_pkg::ALU_CLAMP : ntd_pkg::ALU_BUMP;
      alu_req.note_on = on_ff;
      alu_req.key     = key_ff;
      alu_req.shift   = key_shift_ff;
      alu_req.count   = rd_data_ff;
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      nk_in       = nk_ff;
      emit0_in    = emit0_ff;
      emit1_in    = emit1_ff;
      rd_addr     = key_addr;
      wr_addr     = key_addr;
      wr_data     = alu_rsp.count;
      wr_en       = 1'b0;
      out_load    = 1'b0;
      out_key     = key_ff;
      out_shifted = 1'b0;
      out_last    = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == ntd_pkg::AddrW'(ntd_pkg::Depth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && ch_ok) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // read the original counter, form the companion key
            rd_addr  = key_addr;
            nk_in    = alu_rsp.key;
            state_in = ST_UP0;
         end
         ST_UP0: begin
            wr_addr  = key_addr;
            wr_en    = 1'b1;
            emit0_in = alu_rsp.emit;
            state_in = ST_READ1;
         end
         ST_READ1: begin
            rd_addr  = nk_addr;
            state_in = ST_UP1;
         end
         ST_UP1: begin
            wr_addr  = nk_addr;
            wr_en    = 1'b1;
            emit1_in = alu_rsp.emit;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // hand pending results to the output register in order
            if (emit0_ff) begin
               out_key     = key_ff;
               out_shifted = 1'b0;
               out_last    = !emit1_ff;
               if (out_free) begin
                  out_load = 1'b1;
                  emit0_in = 1'b0;
                  if (!emit1_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (emit1_ff) begin
               out_key     = nk_ff;
               out_shifted = 1'b1;
               out_last    = 1'b1;
               if (out_free) begin
                  out_load = 1'b1;
                  emit1_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_bus.ready);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         key_shift_ff <= ntd_pkg::ShiftReset;
         emit0_ff     <= 1'b0;
         emit1_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         key_shift_ff <= key_shift_in;
         emit0_ff     <= emit0_in;
         emit1_ff     <= emit1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         on_ff  <= req_bus.note_on;
         ch_ff  <= req_bus.channel;
         key_ff <= req_bus.key;
         vel_ff <= req_bus.velocity;
      end
      nk_ff <= nk_in;
      if (out_load) begin
         rsp_on_ff      <= on_ff;
         rsp_ch_ff      <= ch_ff;
         rsp_key_ff     <= out_key;
         rsp_vel_ff     <= vel_ff;
         rsp_shifted_ff <= out_shifted;
         rsp_last_ff    <= out_last;
      end
   end

   // counter memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // result port; all fields come from the output register
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.out_note_on  = rsp_on_ff;
   assign rsp_bus.out_channel  = rsp_ch_ff;
   assign rsp_bus.out_key      = rsp_key_ff;
   assign rsp_bus.out_velocity = rsp_vel_ff;
   assign rsp_bus.is_shifted   = rsp_shifted_ff;
   assign rsp_bus.last         = rsp_last_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // an event is never taken while a result of the previous one is pending
   a_no_take_with_pending: assert property (@(posedge clock) disable iff (reset)
      req_take |-> (!emit0_ff && !emit1_ff))
      else $error("event accepted with results still pending");

   // the output register is never overwritten while its result waits
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_bus.ready))
      else $error("output register overwritten");

   // the counter memory is not written while waiting for an event
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("counter write while idle");

   // an accepted in-range event closes the input for the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_take && ch_ok) |=> !req_bus.ready)
      else $error("input ready right after an accepted event");

endmodule

// ===== bench/note_transpose_doubler_refcount_tb.sv =====
// ----------------------------------------------------------------------------
// note_transpose_doubler_refcount_tb: self-checking bench for the note doubler
// Drives note-on/off transactions with bursty timing, a stalling receiver and
// several key shift settings. A scoreboard keeps its own per-key counts and
// checks every emitted note event in order.
// ----------------------------------------------------------------------------
module note_transpose_doubler_refcount_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 10000; // cycles with no transaction at all
   localparam int Settle    = 16;    // quiet cycles after the last result
   localparam int LongHold  = 300;   // receiver hold-off length
   localparam int MaxPrints = 40;

   typedef logic [ntd_pkg::ChanW-1:0]                chan_type;
   typedef logic [ntd_pkg::KeyW-1:0]                 key_type;
   typedef logic [ntd_pkg::VelW-1:0]                 vel_type;
   typedef logic signed [ntd_pkg::ShiftW-1:0]        shift_type;
   typedef logic signed [ntd_pkg::CountW-1:0]        count_type;
   typedef logic [ntd_pkg::ChanW+ntd_pkg::KeyW-1:0]  held_type;

   typedef struct packed {
      logic     note_on;
      chan_type channel;
      key_type  key;
      vel_type  velocity;
      logic     shifted;
      logic     last;
   } note_result_type;

   typedef enum int {
      RX_OPEN,
      RX_RANDOM,
      RX_PERIODIC
   } rx_mode_type;

   // scoreboard: per-key counts, expected note events, mismatch count
   class note_scoreboard;
      count_type       counts [ntd_pkg::Depth];
      shift_type       key_shift;
      note_result_type pending_notes [$];
      int errors, events_seen, results_seen, saturations, clamps, settings;

      function new();
         foreach (counts[i]) counts[i] = '0;
         key_shift = ntd_pkg::ShiftReset;
         settings  = 1;
      endfunction

      function void set_shift(shift_type value);
         key_shift = value;
         settings++;
      endfunction

      // +1 / -1 with saturation; true when the count crosses into 1 or 0
      function bit step_count(int idx, bit on);
         count_type c;
         c = counts[idx];
         if (on ? (c == ntd_pkg::CountMax) : (c == ntd_pkg::CountMin)) begin
            saturations++;
            return 1'b0;
         end
         c = on ? c + 8'sd1 : c - 8'sd1;
         counts[idx] = c;
         return on ? (c == 8'sd1) : (c == 8'sd0);
      endfunction

      // expected note events for one accepted input transaction
      function void predict_notes(bit on, chan_type ch, key_type key, vel_type vel);
         int              base, companion, n;
         note_result_type outs [2];
         events_seen++;
         if (int'(ch) >= ntd_pkg::Channels) return;
         base      = int'(ch) * ntd_pkg::Keys;
         companion = int'(key) + int'(key_shift);
         if (companion < 0 || companion > ntd_pkg::Keys - 1) clamps++;
         if (companion < 0) companion = 0;
         if (companion > ntd_pkg::Keys - 1) companion = ntd_pkg::Keys - 1;
         n = 0;
         if (step_count(base + int'(key), on)) begin
            outs[n] = '{on, ch, key, vel, 1'b0, 1'b0};
            n++;
         end
         if (step_count(base + companion, on)) begin
            outs[n] = '{on, ch, key_type'(companion), vel, 1'b1, 1'b0};
            n++;
         end
         for (int i = 0; i < n; i++) begin
            outs[i].last = (i == n - 1);
            pending_notes.insert(pending_notes.size(), outs[i]);
         end
      endfunction

      function string fmt(note_result_type r);
         return $sformatf("on=%0d ch=%0d key=%0d vel=%0d sh=%0d last=%0d",
                          r.note_on, r.channel, r.key, r.velocity, r.shifted, r.last);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MaxPrints) $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      // compare one accepted result with the oldest expected note event
      task check_note(note_result_type got);
         note_result_type want;
         string           bad;
         results_seen++;
         if (pending_notes.size() == 0) begin
            report({"unexpected result ", fmt(got)});
            return;
         end
         want = pending_notes.pop_front();
         bad  = "";
         if (got.note_on  !== want.note_on)  bad = {bad, " note_on"};
         if (got.channel  !== want.channel)  bad = {bad, " channel"};
         if (got.key      !== want.key)      bad = {bad, " key"};
         if (got.velocity !== want.velocity) bad = {bad, " velocity"};
         if (got.shifted  !== want.shifted)  bad = {bad, " is_shifted"};
         if (got.last     !== want.last)     bad = {bad, " last"};
         if (bad != "")
            report({"wrong", bad, ": got ", fmt(got), " expected ", fmt(want)});
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   ntd_req_if req_bus ();
   ntd_rsp_if rsp_bus ();
   ntd_csr_if csr_bus ();

   note_scoreboard sb = new();

   // sender pacing and receiver hold-off request
   int burst_left   = 0;
   bit steady       = 1'b0;
   bit hold_request = 1'b0;
   held_type held_notes [$];

   note_transpose_doubler_refcount u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one input transaction, then a random gap at the end of a burst
   task automatic send_note(bit on, chan_type ch, key_type key, vel_type vel);
      int gap;
      req_bus.valid    <= 1'b1;
      req_bus.note_on  <= on;
      req_bus.channel  <= ch;
      req_bus.key      <= key;
      req_bus.velocity <= vel;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.predict_notes(on, ch, key, vel);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap        = steady ? 0 : $urandom_range(0, 10);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // stop offering and wait until every expected note event has come out
   task automatic drain_block();
      req_bus.valid <= 1'b0;
      while (sb.pending_notes.size() != 0) @(posedge clock);
      repeat (Settle) @(posedge clock);
   endtask

   // key shift register write, only while the block is idle
   task automatic change_shift(shift_type value);
      drain_block();
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      sb.set_shift(value);
   endtask

   // keys bunched at both ends of the range to hit companion clamping, and around the middle
   function automatic key_type pick_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return key_type'($urandom_range(0, 8));
      if (r < 6) return key_type'($urandom_range(119, 127));
      if (r < 8) return key_type'($urandom_range(56, 72));
      return key_type'($urandom_range(0, 127));
   endfunction

   // mostly balanced on/off pairs on few keys, with some raw noise
   task automatic random_phase(int count, int hold_at, int drain_at);
      int       r, idx;
      chan_type ch;
      key_type  key;
      held_type note;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at) hold_request = 1'b1;
         if (i == drain_at) drain_block();
         r = $urandom_range(0, 99);
         if (r < 10) begin
            send_note(1'($urandom_range(0, 1)), chan_type'($urandom_range(0, 15)),
                      key_type'($urandom_range(0, 127)), vel_type'($urandom_range(0, 127)));
         end else if (held_notes.size() > 0 && (r < 52 || held_notes.size() > 12)) begin
            idx  = $urandom_range(0, held_notes.size() - 1);
            note = held_notes[idx];
            held_notes.delete(idx);
            send_note(1'b0, note[ntd_pkg::ChanW+ntd_pkg::KeyW-1:ntd_pkg::KeyW],
                      note[ntd_pkg::KeyW-1:0], vel_type'($urandom_range(0, 127)));
         end else begin
            ch  = ($urandom_range(0, 4) != 0) ? chan_type'($urandom_range(0, 3))
                                              : chan_type'($urandom_range(0, 15));
            key = pick_key();
            held_notes.insert(held_notes.size(), {ch, key});
            send_note(1'b1, ch, key, vel_type'($urandom_range(1, 127)));
         end
      end
   endtask

   // receiver: checks results and stalls on its own pattern
   initial begin : receiver
      int              hold_left, mode_left, period, cyc;
      rx_mode_type     mode;
      note_result_type got;
      hold_left = 0;
      mode_left = 0;
      period    = 2;
      cyc       = 0;
      mode      = RX_OPEN;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got = '{rsp_bus.out_note_on, rsp_bus.out_channel, rsp_bus.out_key,
                    rsp_bus.out_velocity, rsp_bus.is_shifted, rsp_bus.last};
            sb.check_note(got);
         end
         cyc++;
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(40, 160);
            period    = $urandom_range(2, 5);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LongHold;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN: begin
                  rsp_bus.ready <= 1'b1;
               end
               RX_RANDOM: begin
                  rsp_bus.ready <= ($urandom_range(0, 9) < 6);
               end
               default: begin
                  rsp_bus.ready <= (cyc % period) != 0;
               end
            endcase
         end
      end
   end

   // watchdog: ends the run after too long without any transaction
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no transaction for %0d cycles", IdleLimit);
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.note_on  <= 1'b0;
      req_bus.channel  <= '0;
      req_bus.key      <= '0;
      req_bus.velocity <= '0;
      csr_bus.valid    <= 1'b0;
      csr_bus.data     <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset shift of 7: pairs, top-key clamp onto itself, unbalanced note-off
      send_note(1'b1, 4'd0, 7'd60, 7'd100);
      send_note(1'b0, 4'd0, 7'd60, 7'd0);
      send_note(1'b1, 4'd15, 7'd127, 7'd127);
      send_note(1'b0, 4'd15, 7'd127, 7'd1);
      send_note(1'b0, 4'd3, 7'd10, 7'd20);
      send_note(1'b1, 4'd3, 7'd10, 7'd21);
      send_note(1'b1, 4'd3, 7'd10, 7'd22);
      send_note(1'b1, 4'd3, 7'd3, 7'd5);
      send_note(1'b0, 4'd3, 7'd10, 7'd42);

      // most negative shift: companion clamps to key 0
      change_shift(shift_type'(-32));
      send_note(1'b1, 4'd7, 7'd0, 7'd64);
      send_note(1'b1, 4'd7, 7'd20, 7'd85);
      send_note(1'b1, 4'd7, 7'd31, 7'd42);
      send_note(1'b0, 4'd7, 7'd0, 7'd127);

      // most positive shift: companion clamps to key 127
      change_shift(6'sd31);
      send_note(1'b1, 4'd8, 7'd96, 7'd10);
      send_note(1'b1, 4'd8, 7'd100, 7'd11);
      send_note(1'b0, 4'd8, 7'd96, 7'd12);
      send_note(1'b0, 4'd8, 7'd100, 7'd13);

      // zero shift: both updates land on one counter
      change_shift(6'sd0);
      send_note(1'b1, 4'd9, 7'd64, 7'd33);
      send_note(1'b0, 4'd9, 7'd64, 7'd34);

      // saturation: run one counter up to 127, down to -128, back to 0
      for (int i = 0; i < 65; i++)
         send_note(1'b1, 4'd5, 7'd60, vel_type'($urandom_range(0, 127)));
      for (int i = 0; i < 130; i++)
         send_note(1'b0, 4'd5, 7'd60, vel_type'($urandom_range(0, 127)));
      for (int i = 0; i < 64; i++)
         send_note(1'b1, 4'd5, 7'd60, vel_type'($urandom_range(0, 127)));

      // random phases over several shift settings
      change_shift(6'sd24);
      random_phase(100, -1, -1);
      change_shift(-6'sd24);
      random_phase(100, 30, -1);
      change_shift(shift_type'($urandom_range(0, 63)));
      random_phase(100, -1, 50);
      change_shift(-6'sd1);
      steady = 1'b1;
      random_phase(100, -1, -1);
      steady = 1'b0;
      change_shift(6'sd3);
      random_phase(100, 60, -1);

      drain_block();
      if (sb.pending_notes.size() != 0)
         sb.report($sformatf("%0d expected results never came", sb.pending_notes.size()));
      $display("covered %0d note events and %0d results, %0d saturated updates, %0d clamps",
               sb.events_seen, sb.results_seen, sb.saturations, sb.clamps);
      $display("over %0d key shift settings, with a long output stall and mid-run drains",
               sb.settings);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
